// ===== hdl/mfep_pkg.sv =====
// Shared types, codes and helper functions of the MIDI file event parser.
package mfep_pkg;

    // Default width of the per-track tick counter
    localparam int TICK_BITS_DEF = 32;

    // Parser phases
    typedef enum logic [3:0] {
        PH_FILE   = 4'd0,
        PH_CHUNK  = 4'd1,
        PH_DELTA  = 4'd2,
        PH_STATUS = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_SXLEN  = 4'd6,
        PH_DA     = 4'd7,
        PH_DB     = 4'd8,
        PH_SKIP   = 4'd9,
        PH_HALT   = 4'd10
    } phase_t;

    // Record codes
    localparam logic [3:0] REC_HEADER  = 4'd0;
    localparam logic [3:0] REC_TRACK   = 4'd1;
    localparam logic [3:0] REC_META    = 4'd2;
    localparam logic [3:0] REC_SYSEX   = 4'd3;
    localparam logic [3:0] REC_OFF     = 4'd4;
    localparam logic [3:0] REC_ON      = 4'd5;
    localparam logic [3:0] REC_ON_VEL0 = 4'd6;
    localparam logic [3:0] REC_CONTROL = 4'd7;
    localparam logic [3:0] REC_PROGRAM = 4'd8;
    localparam logic [3:0] REC_BEND    = 4'd9;
    localparam logic [3:0] REC_OTHER   = 4'd10;
    localparam logic [3:0] REC_STOP    = 4'd11;

    // Status bytes and status kinds (low nibble cleared)
    localparam logic [7:0] ST_META     = 8'hff;
    localparam logic [7:0] ST_SYSEX    = 8'hf0;
    localparam logic [7:0] ST_SYSEX_CT = 8'hf7;
    localparam logic [7:0] KIND_OFF    = 8'h80;
    localparam logic [7:0] KIND_ON     = 8'h90;
    localparam logic [7:0] KIND_CTRL   = 8'hb0;
    localparam logic [7:0] KIND_PROG   = 8'hc0;
    localparam logic [7:0] KIND_PRESS  = 8'hd0;
    localparam logic [7:0] KIND_BEND   = 8'he0;
    localparam logic [7:0] VLQ_MASK    = 8'h7f;

    // Chunk header and file header lengths as last field index, and the chunk tag length
    localparam logic [3:0] FILE_HDR_LAST  = 4'd13;
    localparam logic [3:0] CHUNK_HDR_LAST = 4'd7;
    localparam logic [3:0] CHUNK_TAG_LEN  = 4'd4;

    // One result item
    typedef struct packed {
        logic [3:0]  record;
        logic [31:0] tick;
        logic [3:0]  channel;
        logic [7:0]  status_high;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [13:0] bend_value;
        logic [31:0] length;
        logic [15:0] track_number;
        logic [15:0] header_format;
        logic [15:0] header_tracks;
        logic [15:0] header_division;
    } result_t;

    // Expected "MTrk" tag byte at a position
    function automatic logic [7:0] tag_byte(input logic [1:0] idx);
        logic [7:0] val;
        unique case (idx)
            2'd0: val = 8'h4d;
            2'd1: val = 8'h54;
            2'd2: val = 8'h72;
            default: val = 8'h6b;
        endcase
        return val;
    endfunction

    // Phase that follows a status byte
    function automatic phase_t phase_for(input logic [7:0] status);
        phase_t ph;
        if (status == ST_META)
            ph = PH_MTYPE;
        else if (status == ST_SYSEX || status == ST_SYSEX_CT)
            ph = PH_SXLEN;
        else
            ph = PH_DA;
        return ph;
    endfunction

    // True for statuses that carry one data byte
    function automatic logic one_data(input logic [7:0] status);
        return ({status[7:4], 4'h0} == KIND_PROG) || ({status[7:4], 4'h0} == KIND_PRESS);
    endfunction

    // Record code of a channel event
    function automatic logic [3:0] chan_rec(input logic [7:0] status,
                                            input logic [7:0] second);
        logic [7:0] kind;
        logic [3:0] rec;
        kind = {status[7:4], 4'h0};
        priority if (kind == KIND_OFF)
            rec = REC_OFF;
        else if (kind == KIND_ON)
            rec = (second == 8'h00) ? REC_ON_VEL0 : REC_ON;
        else if (kind == KIND_CTRL)
            rec = REC_CONTROL;
        else if (kind == KIND_PROG)
            rec = REC_PROGRAM;
        else if (kind == KIND_BEND)
            rec = REC_BEND;
        else
            rec = REC_OTHER;
        return rec;
    endfunction

endpackage

// ===== hdl/mfep_in_if.sv =====
// Byte request channel of the MIDI file event parser.
interface mfep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/mfep_out_if.sv =====
// Event request channel of the MIDI file event parser.
interface mfep_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  record;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [7:0]  status_high;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [13:0] bend_value;
    logic [31:0] length;
    logic [15:0] track_number;
    logic [15:0] header_format;
    logic [15:0] header_tracks;
    logic [15:0] header_division;

    modport source (output valid, output record, output tick, output channel,
                    output status_high, output first_data, output second_data,
                    output bend_value, output length, output track_number,
                    output header_format, output header_tracks,
                    output header_division, input ready);
    modport sink (input valid, input record, input tick, input channel,
                  input status_high, input first_data, input second_data,
                  input bend_value, input length, input track_number,
                  input header_format, input header_tracks,
                  input header_division, output ready);
endinterface

// ===== hdl/midi_file_event_parser_top.sv =====
// Top level of the MIDI file event parser.
// Takes a Standard MIDI File one byte per request on "stream" and gives header,
// track, meta, sysex, channel and stop records on "events". Every byte is
// decoded in the cycle it is accepted, so the parser takes one byte per clock
// while its skid stage is empty. A completed record is registered in the
// output register, which is backed by a one-entry skid stage, so bytes keep
// flowing while a record waits; "stream.ready" drops only when both hold a
// record. The tick counter is TICK_BITS wide and its low 32 bits are reported.
// After a byte flagged last_byte the parser is back at the start of a new
// file. There is no start-up sweep: the parser is ready right after reset.
module midi_file_event_parser_top #(
    parameter int TICK_BITS = mfep_pkg::TICK_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mfep_in_if.sink    stream,
    mfep_out_if.source events
);

    logic              take;
    logic              room;
    logic              res_valid;
    mfep_pkg::result_t res;

    assign stream.ready = room;
    assign take         = stream.valid && room;

    mfep_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (stream.data_byte),
        .last_byte (stream.last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    mfep_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .room      (room),
        .events    (events)
    );

endmodule

// ===== hdl/mfep_core.sv =====
// Parser state and per-byte decode of the MIDI file event parser.
module mfep_core #(
    parameter int TICK_BITS = mfep_pkg::TICK_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              res_valid,
    output mfep_pkg::result_t res
);

    mfep_pkg::phase_t       phase_reg, phase_next;
    logic [3:0]             field_reg, field_next;
    logic [31:0]            chunk_rem_reg, chunk_rem_next;
    logic [31:0]            skip_reg, skip_next;
    logic [15:0]            track_reg, track_next;
    logic [TICK_BITS-1:0]   tick_reg, tick_next;
    logic [7:0]             status_reg, status_next;
    logic [31:0]            vlq_reg, vlq_next;
    logic [47:0]            held_reg, held_next;
    logic                   magic_reg, magic_next;

    // Decode of one event byte
    mfep_pkg::phase_t       eff_phase;
    mfep_pkg::phase_t       c_phase;
    logic [7:0]             c_status;
    logic [31:0]            c_vlq;
    logic [31:0]            vlq_in;
    logic [31:0]            vlq_shift;
    logic [47:0]            c_held;
    logic [31:0]            c_skip;
    logic [TICK_BITS-1:0]   c_tick;
    logic                   c_ev;
    logic [3:0]             c_rec;
    logic [7:0]             c_a;
    logic [7:0]             c_b;
    logic [31:0]            c_len;

    // Event closed early at a chunk or file end
    logic                   f_ev;
    logic [3:0]             f_rec;
    logic [7:0]             f_a;
    logic [7:0]             f_b;
    logic [31:0]            f_len;

    logic [47:0]            held_shift;
    logic                   magic_upd;
    logic [31:0]            chunk_dec;
    logic                   end_chunk;
    logic                   ev_sel;
    logic [3:0]             ev_rec;
    logic [7:0]             ev_a;
    logic [7:0]             ev_b;
    logic [31:0]            ev_len;

    assign held_shift = {held_reg[39:0], data_byte};
    assign chunk_dec  = chunk_rem_reg - 32'd1;
    assign end_chunk  = (chunk_dec == 32'd0) || last_byte;
    assign magic_upd  = magic_reg &
                        !((field_reg < mfep_pkg::CHUNK_TAG_LEN) &&
                          (data_byte != mfep_pkg::tag_byte(field_reg[1:0])));

    // Resolve running status and shift the byte into the VLQ
    always_comb
    begin
        if (phase_reg == mfep_pkg::PH_STATUS)
        begin
            eff_phase = mfep_pkg::phase_for(status_reg);
            vlq_in    = 32'd0;
        end
        else
        begin
            eff_phase = phase_reg;
            vlq_in    = vlq_reg;
        end
        vlq_shift = {vlq_in[24:0], data_byte[6:0] & mfep_pkg::VLQ_MASK[6:0]};
    end

    // Consume one event byte
    always_comb
    begin
        c_phase  = eff_phase;
        c_status = status_reg;
        c_vlq    = vlq_in;
        c_held   = held_reg;
        c_skip   = skip_reg;
        c_tick   = tick_reg;
        c_ev     = 1'b0;
        c_rec    = mfep_pkg::REC_OTHER;
        c_a      = 8'h00;
        c_b      = 8'h00;
        c_len    = 32'd0;
        if (phase_reg == mfep_pkg::PH_STATUS && data_byte[7])
        begin
            c_status = data_byte;
            c_phase  = mfep_pkg::phase_for(data_byte);
            c_vlq    = 32'd0;
        end
        else
        begin
            unique case (eff_phase)
                mfep_pkg::PH_DELTA:
                begin
                    c_vlq = vlq_shift;
                    if (!data_byte[7])
                    begin
                        c_tick  = tick_reg + TICK_BITS'(vlq_shift);
                        c_vlq   = 32'd0;
                        c_phase = mfep_pkg::PH_STATUS;
                    end
                end
                mfep_pkg::PH_MTYPE:
                begin
                    c_held  = {40'd0, data_byte};
                    c_vlq   = 32'd0;
                    c_phase = mfep_pkg::PH_MLEN;
                end
                mfep_pkg::PH_MLEN, mfep_pkg::PH_SXLEN:
                begin
                    c_vlq = vlq_shift;
                    if (!data_byte[7])
                    begin
                        c_ev    = 1'b1;
                        c_rec   = (eff_phase == mfep_pkg::PH_MLEN) ?
                                  mfep_pkg::REC_META : mfep_pkg::REC_SYSEX;
                        c_a     = (eff_phase == mfep_pkg::PH_MLEN) ? held_reg[7:0] : 8'h00;
                        c_len   = vlq_shift;
                        c_skip  = vlq_shift;
                        c_vlq   = 32'd0;
                        c_phase = (vlq_shift == 32'd0) ? mfep_pkg::PH_DELTA :
                                                         mfep_pkg::PH_SKIP;
                    end
                end
                mfep_pkg::PH_DA:
                begin
                    if (mfep_pkg::one_data(status_reg))
                    begin
                        c_ev    = 1'b1;
                        c_rec   = mfep_pkg::chan_rec(status_reg, 8'h00);
                        c_a     = data_byte;
                        c_phase = mfep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        c_held  = {40'd0, data_byte};
                        c_phase = mfep_pkg::PH_DB;
                    end
                end
                mfep_pkg::PH_DB:
                begin
                    c_ev    = 1'b1;
                    c_rec   = mfep_pkg::chan_rec(status_reg, data_byte);
                    c_a     = held_reg[7:0];
                    c_b     = data_byte;
                    c_phase = mfep_pkg::PH_DELTA;
                end
                mfep_pkg::PH_SKIP:
                begin
                    c_skip = skip_reg - 32'd1;
                    if (c_skip == 32'd0)
                        c_phase = mfep_pkg::PH_DELTA;
                end
                default:
                begin
                    c_phase = eff_phase;
                end
            endcase
        end
    end

    // Close a pending event with missing bytes read as zero
    always_comb
    begin
        f_ev  = 1'b1;
        f_rec = mfep_pkg::REC_OTHER;
        f_a   = 8'h00;
        f_b   = 8'h00;
        f_len = 32'd0;
        unique case (c_phase)
            mfep_pkg::PH_MTYPE:
                f_rec = mfep_pkg::REC_META;
            mfep_pkg::PH_MLEN:
            begin
                f_rec = mfep_pkg::REC_META;
                f_a   = c_held[7:0];
                f_len = c_vlq;
            end
            mfep_pkg::PH_SXLEN:
            begin
                f_rec = mfep_pkg::REC_SYSEX;
                f_len = c_vlq;
            end
            mfep_pkg::PH_DA:
                f_rec = mfep_pkg::chan_rec(c_status, 8'h00);
            mfep_pkg::PH_DB:
            begin
                f_rec = mfep_pkg::chan_rec(c_status, 8'h00);
                f_a   = c_held[7:0];
            end
            default:
                f_ev = 1'b0;
        endcase
    end

    // Pick the byte's own event first, the closing event otherwise
    always_comb
    begin
        ev_sel = c_ev || (end_chunk && f_ev);
        if (c_ev)
        begin
            ev_rec = c_rec;
            ev_a   = c_a;
            ev_b   = c_b;
            ev_len = c_len;
        end
        else
        begin
            ev_rec = f_rec;
            ev_a   = f_a;
            ev_b   = f_b;
            ev_len = f_len;
        end
    end

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        field_next     = field_reg;
        chunk_rem_next = chunk_rem_reg;
        skip_next      = skip_reg;
        track_next     = track_reg;
        tick_next      = tick_reg;
        status_next    = status_reg;
        vlq_next       = vlq_reg;
        held_next      = held_reg;
        magic_next     = magic_reg;
        if (take)
        begin
            unique case (phase_reg)
                mfep_pkg::PH_FILE:
                begin
                    held_next = held_shift;
                    if (field_reg >= mfep_pkg::FILE_HDR_LAST)
                    begin
                        phase_next = mfep_pkg::PH_CHUNK;
                        field_next = 4'd0;
                        magic_next = 1'b1;
                    end
                    else
                        field_next = field_reg + 4'd1;
                end
                mfep_pkg::PH_CHUNK:
                begin
                    held_next  = held_shift;
                    magic_next = magic_upd;
                    if (field_reg >= mfep_pkg::CHUNK_HDR_LAST)
                    begin
                        if (!magic_upd)
                            phase_next = mfep_pkg::PH_HALT;
                        else
                        begin
                            chunk_rem_next = held_shift[31:0];
                            track_next     = track_reg + 16'd1;
                            tick_next      = '0;
                            status_next    = 8'h00;
                            vlq_next       = 32'd0;
                            skip_next      = 32'd0;
                            if (held_shift[31:0] == 32'd0)
                            begin
                                phase_next = mfep_pkg::PH_CHUNK;
                                field_next = 4'd0;
                                magic_next = 1'b1;
                            end
                            else
                                phase_next = mfep_pkg::PH_DELTA;
                        end
                    end
                    else
                        field_next = field_reg + 4'd1;
                end
                mfep_pkg::PH_HALT:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    chunk_rem_next = chunk_dec;
                    phase_next     = c_phase;
                    status_next    = c_status;
                    vlq_next       = c_vlq;
                    held_next      = c_held;
                    skip_next      = c_skip;
                    tick_next      = c_tick;
                    if (end_chunk)
                    begin
                        phase_next = mfep_pkg::PH_CHUNK;
                        field_next = 4'd0;
                        magic_next = 1'b1;
                    end
                end
            endcase
            // Return to the start of a file after its last byte
            if (last_byte)
            begin
                phase_next     = mfep_pkg::PH_FILE;
                field_next     = 4'd0;
                chunk_rem_next = 32'd0;
                skip_next      = 32'd0;
                track_next     = 16'd0;
                tick_next      = '0;
                status_next    = 8'h00;
                vlq_next       = 32'd0;
                held_next      = 48'd0;
                magic_next     = 1'b1;
            end
        end
    end

    // Result of the byte
    always_comb
    begin
        res       = '0;
        res_valid = 1'b0;
        if (take)
        begin
            unique case (phase_reg)
                mfep_pkg::PH_FILE:
                begin
                    if (field_reg >= mfep_pkg::FILE_HDR_LAST)
                    begin
                        res_valid           = 1'b1;
                        res.record          = mfep_pkg::REC_HEADER;
                        res.header_format   = held_shift[47:32];
                        res.header_tracks   = held_shift[31:16];
                        res.header_division = held_shift[15:0];
                    end
                end
                mfep_pkg::PH_CHUNK:
                begin
                    if (field_reg >= mfep_pkg::CHUNK_HDR_LAST)
                    begin
                        res_valid = 1'b1;
                        if (!magic_upd)
                            res.record = mfep_pkg::REC_STOP;
                        else
                        begin
                            res.record       = mfep_pkg::REC_TRACK;
                            res.length       = held_shift[31:0];
                            res.track_number = track_reg;
                        end
                    end
                end
                mfep_pkg::PH_HALT:
                begin
                    res_valid = 1'b0;
                end
                default:
                begin
                    if (ev_sel)
                    begin
                        res_valid        = 1'b1;
                        res.record       = ev_rec;
                        res.tick         = 32'(c_tick);
                        res.channel      = c_status[3:0];
                        res.status_high  = {c_status[7:4], 4'h0};
                        res.first_data   = ev_a;
                        res.second_data  = ev_b;
                        res.bend_value   = (ev_rec == mfep_pkg::REC_BEND) ?
                                           ({ev_b[6:0], 7'd0} | {6'd0, ev_a}) : 14'd0;
                        res.length       = ev_len;
                        res.track_number = track_reg - 16'd1;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mfep_pkg::PH_FILE;
            field_reg     <= 4'd0;
            chunk_rem_reg <= 32'd0;
            skip_reg      <= 32'd0;
            track_reg     <= 16'd0;
            tick_reg      <= '0;
            status_reg    <= 8'h00;
            vlq_reg       <= 32'd0;
            held_reg      <= 48'd0;
            magic_reg     <= 1'b1;
        end
        else
        begin
            phase_reg     <= phase_next;
            field_reg     <= field_next;
            chunk_rem_reg <= chunk_rem_next;
            skip_reg      <= skip_next;
            track_reg     <= track_next;
            tick_reg      <= tick_next;
            status_reg    <= status_next;
            vlq_reg       <= vlq_next;
            held_reg      <= held_next;
            magic_reg     <= magic_next;
        end
    end

endmodule

// ===== hdl/mfep_outbuf.sv =====
// Result register with a skid stage for the MIDI file event parser.
module mfep_outbuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mfep_pkg::result_t push_data,
    output logic              room,
    mfep_out_if.source        events
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    mfep_pkg::result_t out_data_reg, out_data_next;
    mfep_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign room = !skid_valid_reg;
    assign pop  = out_valid_reg && events.ready;

    // Move results between the skid and the output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            out_valid_next = 1'b0;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Drive the event request
    assign events.valid           = out_valid_reg;
    assign events.record          = out_data_reg.record;
    assign events.tick            = out_data_reg.tick;
    assign events.channel         = out_data_reg.channel;
    assign events.status_high     = out_data_reg.status_high;
    assign events.first_data      = out_data_reg.first_data;
    assign events.second_data     = out_data_reg.second_data;
    assign events.bend_value      = out_data_reg.bend_value;
    assign events.length          = out_data_reg.length;
    assign events.track_number    = out_data_reg.track_number;
    assign events.header_format   = out_data_reg.header_format;
    assign events.header_tracks   = out_data_reg.header_tracks;
    assign events.header_division = out_data_reg.header_division;

endmodule
